// ----- design/sdtq_pkg.sv -----
`timescale 1ns / 1ps

package sdtq_pkg;

    localparam int NUM_IDS           = 16;
    localparam int ID_W              = 4;
    localparam int OP_W              = 2;
    localparam int STATUS_W          = 3;
    localparam int FIELD_TIME_W      = 64;
    localparam int DEFAULT_DEPTH     = 16;
    localparam int DEFAULT_TIME_BITS = 64;

    localparam int IN_FIELDS_W  = OP_W + ID_W + 2 * FIELD_TIME_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = ID_W + STATUS_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int OP_LSB  = 0;
    localparam int ID_LSB  = OP_LSB + OP_W;
    localparam int DL_LSB  = ID_LSB + ID_W;
    localparam int NOW_LSB = DL_LSB + FIELD_TIME_W;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
    localparam logic [OP_W-1:0] OP_CHECK  = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK         = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_EXPIRED    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_ALREADY    = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_NOT_QUEUED = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NONE_DUE   = 3'd4;

    typedef struct packed {
        logic                capture;
        logic                eval;
        logic                do_insert;
        logic                do_remove;
        logic                do_pop;
        logic                load_out;
        logic                out_from_head;
        logic                out_zero;
        logic [STATUS_W-1:0] out_status;
        logic                out_last;
    } sdtq_cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            queued;
        logic            full;
        logic            due0;
        logic            due1;
    } sdtq_stat_t;

endpackage

// ----- design/sdtq_datapath.sv -----
`timescale 1ns / 1ps

module sdtq_datapath
    import sdtq_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int TIME_BITS = DEFAULT_TIME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  sdtq_cmd_t             cmd,
    output sdtq_stat_t            stat,
    output logic [OUT_DATA_W-1:0] out_data,
    output logic                  out_last
);

    localparam int CAP   = (DEPTH < NUM_IDS) ? DEPTH : NUM_IDS;
    localparam int CNT_W = $clog2(CAP + 1);

    logic [OP_W-1:0]      op_reg;
    logic [ID_W-1:0]      id_reg;
    logic [TIME_BITS-1:0] ts_reg;
    logic [TIME_BITS-1:0] now_reg;

    logic [ID_W-1:0]      slot_id_reg [CAP];
    logic [TIME_BITS-1:0] slot_dl_reg [CAP];
    logic [CNT_W-1:0]     count_reg;
    logic [NUM_IDS-1:0]   flags_reg;

    logic [CAP-1:0] greater_reg;
    logic [CAP-1:0] before_reg;
    logic           due0_reg;
    logic           due1_reg;

    logic [ID_W-1:0]     o_id_reg;
    logic [STATUS_W-1:0] o_status_reg;
    logic                o_last_reg;

    logic [CAP-1:0] greater_vec;
    logic [CAP-1:0] match_vec;
    logic [CAP-1:0] before_vec;

    always_comb
    begin
        for (int i = 0; i < CAP; i++)
        begin
            greater_vec[i] = (CNT_W'(i) < count_reg) && (slot_dl_reg[i] > ts_reg);
            match_vec[i]   = (CNT_W'(i) < count_reg) && (slot_id_reg[i] == id_reg);
        end
        for (int i = 0; i < CAP; i++)
        begin
            before_vec[i] = 1'b0;
            for (int j = 0; j < CAP; j++)
            begin
                if (j <= i)
                begin
                    before_vec[i] = before_vec[i] | match_vec[j];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg  <= in_data[OP_LSB +: OP_W];
            id_reg  <= in_data[ID_LSB +: ID_W];
            ts_reg  <= in_data[DL_LSB +: TIME_BITS];
            now_reg <= in_data[NOW_LSB +: TIME_BITS];
        end
        if (cmd.eval)
        begin
            greater_reg <= greater_vec;
            before_reg  <= before_vec;
            due0_reg    <= (count_reg > CNT_W'(0)) && (now_reg >= slot_dl_reg[0]);
            due1_reg    <= (count_reg > CNT_W'(1)) && (now_reg >= slot_dl_reg[1]);
        end
        if (cmd.load_out)
        begin
            o_status_reg <= cmd.out_status;
            o_last_reg   <= cmd.out_last;
            if (cmd.out_zero)
            begin
                o_id_reg <= '0;
            end
            else if (cmd.out_from_head)
            begin
                o_id_reg <= slot_id_reg[0];
            end
            else
            begin
                o_id_reg <= id_reg;
            end
        end
        if (cmd.do_insert)
        begin
            if ((count_reg == CNT_W'(0)) || greater_reg[0])
            begin
                slot_id_reg[0] <= id_reg;
                slot_dl_reg[0] <= ts_reg;
            end
            for (int i = 1; i < CAP; i++)
            begin
                if (greater_reg[i-1])
                begin
                    slot_id_reg[i] <= slot_id_reg[i-1];
                    slot_dl_reg[i] <= slot_dl_reg[i-1];
                end
                else if ((CNT_W'(i) == count_reg) || greater_reg[i])
                begin
                    slot_id_reg[i] <= id_reg;
                    slot_dl_reg[i] <= ts_reg;
                end
            end
        end
        else if (cmd.do_remove || cmd.do_pop)
        begin
            for (int i = 0; i < CAP - 1; i++)
            begin
                if (cmd.do_pop || before_reg[i])
                begin
                    slot_id_reg[i] <= slot_id_reg[i+1];
                    slot_dl_reg[i] <= slot_dl_reg[i+1];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            flags_reg <= '0;
        end
        else if (cmd.do_insert)
        begin
            count_reg         <= count_reg + CNT_W'(1);
            flags_reg[id_reg] <= 1'b1;
        end
        else if (cmd.do_remove)
        begin
            count_reg         <= count_reg - CNT_W'(1);
            flags_reg[id_reg] <= 1'b0;
        end
        else if (cmd.do_pop)
        begin
            count_reg                 <= count_reg - CNT_W'(1);
            flags_reg[slot_id_reg[0]] <= 1'b0;
        end
    end

    assign stat.op     = op_reg;
    assign stat.queued = flags_reg[id_reg];
    assign stat.full   = (count_reg == CNT_W'(CAP));
    assign stat.due0   = due0_reg;
    assign stat.due1   = due1_reg;

    assign out_data = {{(OUT_DATA_W - OUT_FIELDS_W){1'b0}}, o_status_reg, o_id_reg};
    assign out_last = o_last_reg;

endmodule

// ----- design/sdtq_ctrl.sv -----
`timescale 1ns / 1ps

module sdtq_ctrl
    import sdtq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  sdtq_stat_t stat,
    output sdtq_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_DECIDE,
        S_SEND
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   valid_reg;
    logic   valid_next;
    logic   last_reg;
    logic   last_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        valid_next = valid_reg;
        last_next  = last_reg;
        cmd.capture = in_valid && (state_reg == S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                cmd.load_out = 1'b1;
                cmd.out_last = 1'b1;
                state_next   = S_SEND;
                valid_next   = 1'b1;
                case (stat.op)
                    OP_INSERT:
                    begin
                        if (stat.queued)
                        begin
                            cmd.out_status = STAT_ALREADY;
                        end
                        else if (stat.full)
                        begin
                            cmd.out_status = STAT_NOT_QUEUED;
                        end
                        else
                        begin
                            cmd.out_status = STAT_OK;
                            cmd.do_insert  = 1'b1;
                        end
                    end
                    OP_CANCEL:
                    begin
                        if (stat.queued)
                        begin
                            cmd.out_status = STAT_OK;
                            cmd.do_remove  = 1'b1;
                        end
                        else
                        begin
                            cmd.out_status = STAT_NOT_QUEUED;
                        end
                    end
                    OP_CHECK:
                    begin
                        if (stat.due0)
                        begin
                            cmd.out_status    = STAT_EXPIRED;
                            cmd.out_from_head = 1'b1;
                            cmd.out_last      = !stat.due1;
                            cmd.do_pop        = 1'b1;
                        end
                        else
                        begin
                            cmd.out_status = STAT_NONE_DUE;
                            cmd.out_zero   = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.load_out = 1'b0;
                        state_next   = S_IDLE;
                        valid_next   = 1'b0;
                    end
                endcase
                last_next = cmd.out_last;
            end
            S_SEND:
            begin
                if (out_ready)
                begin
                    valid_next = 1'b0;
                    state_next = last_reg ? S_IDLE : S_EVAL;
                end
            end
            default:
            begin
                state_next = S_IDLE;
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = valid_reg;

endmodule

// ----- design/sorted_deadline_timer_queue.sv -----
`timescale 1ns / 1ps

// Sorted deadline timer queue.
// Commands arrive on the s_ stream: insert an entry with a deadline, cancel an
// entry, or present the current time. Results leave on the m_ stream, one
// transaction each, with tlast on the final result of a command.
// Entries are held in ascending deadline order; equal deadlines keep their
// insertion order. A time check pops every due entry from the head, one
// expired result per entry, or gives a single none-due result.
// Sequence: a command is taken in the idle state, evaluated in the next cycle,
// decided in the cycle after that, and its result is then shown in the send
// state until the receiver takes it; an insert or cancel then returns to idle
// for the next command. A time check passes through the evaluate, decide and
// send steps of the controller once per expired entry, around the slot shift.
// s_tready is low while a command is in progress, including while a result
// waits; a stalled receiver simply holds the result and the queue state.
// After reset the queue is empty and every entry is free; no clearing pass
// is needed.

module sorted_deadline_timer_queue
    import sdtq_pkg::*;
#(
    parameter int DEPTH     = DEFAULT_DEPTH,
    parameter int TIME_BITS = DEFAULT_TIME_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // opcode, entry_id, deadline, now, zero fill
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // entry_id_out, status, zero fill
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast
);

    sdtq_cmd_t  cmd;
    sdtq_stat_t stat;

    sdtq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    sdtq_datapath #(
        .DEPTH     (DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata),
        .out_last (m_tlast)
    );

endmodule

// ----- design/sdtq_checker.sv -----
`timescale 1ns / 1ps

module sdtq_checker
    import sdtq_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic [IN_DATA_W-1:0]  s_tdata,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("Result changed while stalled.");

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("Command changed while waiting.");

    a_no_accept_pending: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("Command accepted while a result is pending.");

    a_none_due_form: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[ID_W +: STATUS_W] == STAT_NONE_DUE)
        |-> (m_tdata[ID_W-1:0] == '0) && m_tlast)
        else $error("None-due result malformed.");

    a_single_results_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[ID_W +: STATUS_W] != STAT_EXPIRED) |-> m_tlast)
        else $error("Single result without tlast.");

endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
